// ===== rtl/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg
// Shared codes, defaults and control types for the shape table query core.
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int COORD_BITS_DEF  = 16;
	localparam int TAG_W           = 8;
	localparam int LAYER_W         = 4;
	localparam int SHAPE_W         = 2;
	localparam int CLS_W           = LAYER_W + SHAPE_W;
	localparam int KIND_W          = 2;
	localparam int EVAL_LAT        = 3;

	localparam logic [LAYER_W-1:0] ALL_LAYER_RST = 4'd15;

	localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

	localparam logic [SHAPE_W-1:0] SHAPE_BOX  = 2'd0;
	localparam logic [SHAPE_W-1:0] SHAPE_CIRC = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUB,
		ST_SCAN,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic add;
		logic mark;
		logic upd;
		logic rot;
		logic bub;
	} cell_op_t;

endpackage

// ===== rtl/stq_cell.sv =====
// ----------------------------------------------------------------------------
// stq_cell
// One table slot: holds a tagged shape and trades it with its neighbors.
// ----------------------------------------------------------------------------
module stq_cell
	import stq_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_op_t                op,
	input  logic                    prv_v,
	input  logic                    nxt_v,
	input  logic [TAG_W-1:0]        nxt_tag,
	input  logic [CLS_W-1:0]        nxt_cls,
	input  logic [4*COORD_BITS-1:0] nxt_crd,
	input  logic [TAG_W-1:0]        new_tag,
	input  logic [CLS_W-1:0]        new_cls,
	input  logic [4*COORD_BITS-1:0] new_crd,
	output logic                    v,
	output logic [TAG_W-1:0]        tag,
	output logic [CLS_W-1:0]        cls,
	output logic [4*COORD_BITS-1:0] crd
);

	logic                    v_q;
	logic [TAG_W-1:0]        tag_q;
	logic [CLS_W-1:0]        cls_q;
	logic [4*COORD_BITS-1:0] crd_q;
	logic                    ld_new;
	logic                    kill;
	logic                    upd;
	logic                    take;
	logic                    give;

	assign ld_new = op.add && prv_v && !v_q;
	assign kill   = op.mark && v_q && (tag_q == new_tag);
	assign upd    = op.upd && v_q && (tag_q == new_tag);
	assign take   = op.rot || (op.bub && !v_q && nxt_v);
	assign give   = op.bub && !prv_v && v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ld_new) begin
			v_q <= 1'b1;
		end else if (kill) begin
			v_q <= 1'b0;
		end else if (take) begin
			v_q <= nxt_v;
		end else if (give) begin
			v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_new || upd) begin
			cls_q <= new_cls;
			crd_q <= new_crd;
		end else if (take) begin
			cls_q <= nxt_cls;
			crd_q <= nxt_crd;
		end
		if (ld_new) begin
			tag_q <= new_tag;
		end else if (take) begin
			tag_q <= nxt_tag;
		end
	end

	assign v   = v_q;
	assign tag = tag_q;
	assign cls = cls_q;
	assign crd = crd_q;

endmodule

// ===== rtl/stq_eval.sv =====
// ----------------------------------------------------------------------------
// stq_eval
// Three-stage overlap test of the query shape against one table entry.
// ----------------------------------------------------------------------------
module stq_eval
	import stq_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic [LAYER_W-1:0]      all_code,
	input  logic [TAG_W-1:0]        q_tag,
	input  logic [LAYER_W-1:0]      q_layer,
	input  logic [SHAPE_W-1:0]      q_type,
	input  logic [4*COORD_BITS-1:0] q_crd,
	input  logic                    e_v,
	input  logic [TAG_W-1:0]        e_tag,
	input  logic [CLS_W-1:0]        e_cls,
	input  logic [4*COORD_BITS-1:0] e_crd,
	output logic                    hit,
	output logic [TAG_W-1:0]        hit_tag
);

	localparam int CB = COORD_BITS;

	logic signed [CB-1:0] qa, qb, qc, qd, ea, eb, ec, ed;
	logic signed [CB-1:0] bx0, by0, bx1, by1, cx, cy, px, py;
	logic [CB-1:0]        qr, er;
	logic [LAYER_W-1:0]   e_layer;
	logic [SHAPE_W-1:0]   e_type;
	logic                 skip, is_bb, is_bc, is_cb, is_cc, bb_res;
	logic signed [CB:0]   dx, dy;
	logic [CB-1:0]        rs;

	logic                 v_s1, bb_s1, bbres_s1;
	logic signed [CB:0]   dx_s1, dy_s1;
	logic [CB-1:0]        rs_s1;
	logic [TAG_W-1:0]     tag_s1;

	logic                 v_s2, bb_s2, bbres_s2;
	logic signed [2*CB+1:0] sqx_s2, sqy_s2;
	logic [2*CB-1:0]      rs2_s2;
	logic [TAG_W-1:0]     tag_s2;

	logic [2*CB+1:0]      dsum;
	logic                 hit_s3;
	logic [TAG_W-1:0]     tag_s3;

	assign qa = q_crd[0*CB +: CB];
	assign qb = q_crd[1*CB +: CB];
	assign qc = q_crd[2*CB +: CB];
	assign qd = q_crd[3*CB +: CB];
	assign ea = e_crd[0*CB +: CB];
	assign eb = e_crd[1*CB +: CB];
	assign ec = e_crd[2*CB +: CB];
	assign ed = e_crd[3*CB +: CB];

	assign e_layer = e_cls[CLS_W-1:SHAPE_W];
	assign e_type  = e_cls[SHAPE_W-1:0];

	assign skip = !e_v || (e_tag == q_tag) || ((q_layer != all_code) && (q_layer == e_layer));
	assign is_bb = (q_type == SHAPE_BOX) && (e_type == SHAPE_BOX);
	assign is_bc = (q_type == SHAPE_BOX) && (e_type == SHAPE_CIRC);
	assign is_cb = (q_type == SHAPE_CIRC) && (e_type == SHAPE_BOX);
	assign is_cc = (q_type == SHAPE_CIRC) && (e_type == SHAPE_CIRC);

	assign bb_res = (qa <= ec) && (ea <= qc) && (qb <= ed) && (eb <= qd);

	// negative radius counts as zero
	assign qr = qc[CB-1] ? '0 : qc;
	assign er = ec[CB-1] ? '0 : ec;

	always_comb begin
		if (is_bc) begin
			bx0 = qa; by0 = qb; bx1 = qc; by1 = qd; cx = ea; cy = eb;
		end else begin
			bx0 = ea; by0 = eb; bx1 = ec; by1 = ed; cx = qa; cy = qb;
		end
		if (cx < bx0) begin
			px = bx0;
		end else if (cx > bx1) begin
			px = bx1;
		end else begin
			px = cx;
		end
		if (cy < by0) begin
			py = by0;
		end else if (cy > by1) begin
			py = by1;
		end else begin
			py = cy;
		end
		if (is_cc) begin
			dx = (CB+1)'(qa) - (CB+1)'(ea);
			dy = (CB+1)'(qb) - (CB+1)'(eb);
			rs = qr + er;
		end else begin
			dx = (CB+1)'(cx) - (CB+1)'(px);
			dy = (CB+1)'(cy) - (CB+1)'(py);
			rs = is_bc ? er : qr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			hit_s3 <= 1'b0;
		end else begin
			v_s1   <= en && !skip && (is_bb || is_bc || is_cb || is_cc);
			v_s2   <= v_s1;
			hit_s3 <= v_s2 && (bb_s2 ? bbres_s2 : (dsum <= {2'b00, rs2_s2}));
		end
	end

	always_ff @(posedge clk) begin
		bb_s1    <= is_bb;
		bbres_s1 <= bb_res;
		dx_s1    <= dx;
		dy_s1    <= dy;
		rs_s1    <= rs;
		tag_s1   <= e_tag;
		bb_s2    <= bb_s1;
		bbres_s2 <= bbres_s1;
		sqx_s2   <= dx_s1 * dx_s1;
		sqy_s2   <= dy_s1 * dy_s1;
		rs2_s2   <= rs_s1 * rs_s1;
		tag_s2   <= tag_s1;
		tag_s3   <= tag_s2;
	end

	assign dsum = {1'b0, sqx_s2[2*CB:0]} + {1'b0, sqy_s2[2*CB:0]};

	assign hit     = hit_s3;
	assign hit_tag = tag_s3;

endmodule

// ===== rtl/shape_table_collision_query_core.sv =====
// ----------------------------------------------------------------------------
// shape_table_collision_query_core
// Ordered table of tagged boxes and circles with add, remove, update, query.
// ----------------------------------------------------------------------------
// Each beat gives exactly one result beat. Add and update write the table
// when the beat is accepted and are then answered. Remove clears the
// matching slots when accepted and then lets the row of slots close the
// gaps. A query rotates the whole row once past a single three-stage
// overlap tester and waits for the tester to drain; the row length sets
// the query time. One item is in work at a time. The all-layer code
// resets to 15.
module shape_table_collision_query_core
	import stq_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [LAYER_W-1:0]   cfg_wr_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// tag, layer, shape_type, coord_a, coord_b, coord_c, coord_d, zero pad
	input  logic [((14+4*COORD_BITS+7)/8)*8-1:0] s_tdata,
	// kind
	input  logic [KIND_W-1:0]    s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// hit, other_tag, status, zero pad
	output logic [15:0]          m_tdata
);

	localparam int CB    = COORD_BITS;
	localparam int CRD_W = 4 * CB;
	localparam int CNT_W = $clog2(2 * MAX_ENTRIES + 1);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [LAYER_W-1:0] all_code_q;
	logic               accept;
	cell_op_t           op;

	logic [TAG_W-1:0]   in_tag;
	logic [LAYER_W-1:0] in_layer;
	logic [SHAPE_W-1:0] in_type;
	logic [CRD_W-1:0]   in_crd;

	logic [TAG_W-1:0]   q_tag_q;
	logic [LAYER_W-1:0] q_layer_q;
	logic [SHAPE_W-1:0] q_type_q;
	logic [CRD_W-1:0]   q_crd_q;
	logic               found_q;
	logic [TAG_W-1:0]   ftag_q;
	logic               stat_q;

	logic               out_v_q;
	logic               out_hit_q;
	logic [TAG_W-1:0]   out_tag_q;
	logic               out_stat_q;

	logic               cv   [MAX_ENTRIES];
	logic [TAG_W-1:0]   ctag [MAX_ENTRIES];
	logic [CLS_W-1:0]   ccls [MAX_ENTRIES];
	logic [CRD_W-1:0]   ccrd [MAX_ENTRIES];

	logic               scan_en;
	logic               ev_hit;
	logic [TAG_W-1:0]   ev_tag;
	logic               out_free;

	assign in_tag   = s_tdata[7:0];
	assign in_layer = s_tdata[11:8];
	assign in_type  = s_tdata[13:12];
	assign in_crd   = s_tdata[14 +: CRD_W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign scan_en  = (state_q == ST_SCAN) && (cnt_q < CNT_W'(MAX_ENTRIES));
	assign out_free = !out_v_q || m_tready;

	always_comb begin
		op.add  = accept && (s_tuser == KIND_ADD);
		op.mark = accept && (s_tuser == KIND_REMOVE);
		op.upd  = accept && (s_tuser == KIND_UPDATE);
		op.rot  = scan_en;
		op.bub  = (state_q == ST_BUB);
	end

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic             p_v;
		logic             n_v;
		logic [TAG_W-1:0] n_tag;
		logic [CLS_W-1:0] n_cls;
		logic [CRD_W-1:0] n_crd;

		if (i == 0) begin : g_first
			assign p_v = 1'b1;
		end else begin : g_mid
			assign p_v = cv[i-1];
		end

		// the last slot wraps to the first for rotation, sees an empty slot otherwise
		if (i == MAX_ENTRIES - 1) begin : g_last
			assign n_v   = op.rot && cv[0];
			assign n_tag = ctag[0];
			assign n_cls = ccls[0];
			assign n_crd = ccrd[0];
		end else begin : g_inner
			assign n_v   = cv[i+1];
			assign n_tag = ctag[i+1];
			assign n_cls = ccls[i+1];
			assign n_crd = ccrd[i+1];
		end

		stq_cell #(
			.COORD_BITS(COORD_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.op      (op),
			.prv_v   (p_v),
			.nxt_v   (n_v),
			.nxt_tag (n_tag),
			.nxt_cls (n_cls),
			.nxt_crd (n_crd),
			.new_tag (in_tag),
			.new_cls ({in_layer, in_type}),
			.new_crd (in_crd),
			.v       (cv[i]),
			.tag     (ctag[i]),
			.cls     (ccls[i]),
			.crd     (ccrd[i])
		);
	end

	stq_eval #(
		.COORD_BITS(COORD_BITS)
	) u_eval (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (scan_en),
		.all_code (all_code_q),
		.q_tag    (q_tag_q),
		.q_layer  (q_layer_q),
		.q_type   (q_type_q),
		.q_crd    (q_crd_q),
		.e_v      (cv[0]),
		.e_tag    (ctag[0]),
		.e_cls    (ccls[0]),
		.e_crd    (ccrd[0]),
		.hit      (ev_hit),
		.hit_tag  (ev_tag)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_tuser == KIND_REMOVE) begin
						state_d = ST_BUB;
					end else if (s_tuser == KIND_QUERY) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_BUB: begin
				if (cnt_q == CNT_W'(2 * MAX_ENTRIES - 1)) begin
					state_d = ST_RESP;
				end
			end
			ST_SCAN: begin
				if (cnt_q == CNT_W'(MAX_ENTRIES + EVAL_LAT - 1)) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			all_code_q <= ALL_LAYER_RST;
			found_q    <= 1'b0;
			stat_q     <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				all_code_q <= cfg_wr_data;
			end
			if (state_q != state_d) begin
				cnt_q <= '0;
			end else if (state_q == ST_BUB || state_q == ST_SCAN) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (accept) begin
				found_q <= 1'b0;
				stat_q  <= (s_tuser == KIND_ADD) && cv[MAX_ENTRIES-1];
			end else if (ev_hit && !found_q) begin
				found_q <= 1'b1;
			end
			if (state_q == ST_RESP && out_free) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_tag_q   <= in_tag;
			q_layer_q <= in_layer;
			q_type_q  <= in_type;
			q_crd_q   <= in_crd;
			ftag_q    <= '0;
		end else if (ev_hit && !found_q) begin
			ftag_q <= ev_tag;
		end
		if (state_q == ST_RESP && out_free) begin
			out_hit_q  <= found_q;
			out_tag_q  <= ftag_q;
			out_stat_q <= stat_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'd0, out_stat_q, out_tag_q, out_hit_q};

	// occupied slots always form a prefix of the row when idle
	for (genvar j = 0; j < MAX_ENTRIES - 1; j++) begin : g_chk
		a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
			(state_q == ST_IDLE) && cv[j+1] |-> cv[j])
			else $error("table slots not packed");
	end

	a_hit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ev_hit |-> (state_q == ST_SCAN))
		else $error("tester hit outside a query scan");

	a_hit_no_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> !(out_hit_q && out_stat_q))
		else $error("hit and drop reported together");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		op.add && cv[MAX_ENTRIES-1] |=> $stable(cv[MAX_ENTRIES-1]) && stat_q)
		else $error("add into full table not dropped");

endmodule
